// ----- rtl/core/trcw_pkg.sv -----
// Package for the Reno congestion window block: widths, phase codes,
// register map and sequencer state type. Used by every file in rtl/core.
package trcw_pkg;

   localparam int WORD_W     = 32;
   localparam int MSS_W      = 16;
   localparam int DUP_W      = 8;
   localparam int PHASE_W    = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W     = $clog2(WORD_W);

   localparam logic [MSS_W-1:0]   MSS_RESET = 16'd1460;
   localparam logic [DUP_W-1:0]   DUP_ONE   = 8'd1;
   localparam logic [DUP_W-1:0]   FAST_DUPS = 8'd3;
   localparam logic [DUP_W-1:0]   DUP_MAX   = 8'd255;

   localparam logic [PHASE_W-1:0] PHASE_OPEN     = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_DISORDER = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_RECOVERY = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_UNUSED   = 2'd3;

   localparam logic CMD_ESTABLISH = 1'b0;
   localparam logic CSR_IDX_SEGMENT_SIZE = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_GROW   = 5'b01000,
      ST_PUSH   = 5'b10000
   } seq_state_type;

endpackage

// ----- rtl/core/trcw_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on trcw_pkg. A zero divisor gives an all-ones quotient.
module trcw_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [trcw_pkg::WORD_W-1:0] dividend,
   input  logic [trcw_pkg::WORD_W-1:0] divisor,
   output logic                        done,
   output logic [trcw_pkg::WORD_W-1:0] quotient
);

   logic                          active_ff, active_in;
   logic                          done_ff, done_in;
   logic [trcw_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [trcw_pkg::WORD_W-1:0]   rem_ff, rem_in;
   logic [trcw_pkg::WORD_W-1:0]   quo_ff, quo_in;
   logic [trcw_pkg::WORD_W-1:0]   dvs_ff, dvs_in;
   logic [trcw_pkg::WORD_W:0]     trial;
   logic [trcw_pkg::WORD_W+1:0]   diff;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[trcw_pkg::WORD_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign fits  = ~diff[trcw_pkg::WORD_W+1];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = '0;
         quo_in    = dividend;
         dvs_in    = divisor;
      end else if (active_ff) begin
         rem_in  = fits ? diff[trcw_pkg::WORD_W-1:0] : trial[trcw_pkg::WORD_W-1:0];
         quo_in  = {quo_ff[trcw_pkg::WORD_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == trcw_pkg::STEP_W'(trcw_pkg::WORD_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/tcp_reno_congestion_window.sv -----
// Reno congestion window of one sending connection, with APB register port.
// Without avoidance growth an accepted item goes through the evaluate and push states;
// with it, divide and grow come between, paced by the 32-step bit-serial divider.
// One transaction in flight: none is accepted until the push, which rsp_ready can hold off.
// Synchronous active-high reset: window state cleared, phase open, segment size 1460.
// Depends on trcw_pkg and trcw_div.
module tcp_reno_congestion_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [trcw_pkg::WORD_W-1:0]     req_ack_num,
   input  logic [trcw_pkg::WORD_W-1:0]     req_snd_next,
   input  logic [trcw_pkg::MSS_W-1:0]      req_peer_window,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [trcw_pkg::WORD_W-1:0]     rsp_cong_window,
   output logic [trcw_pkg::WORD_W-1:0]     rsp_slow_start_limit,
   output logic [trcw_pkg::PHASE_W-1:0]    rsp_cong_phase,
   output logic                            rsp_retransmit,
   output logic                            rsp_window_reopened,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [trcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [trcw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [trcw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   trcw_pkg::seq_state_type state_ff, state_in;

   logic [trcw_pkg::MSS_W-1:0]   mss_ff, mss_in;
   logic                         cmd_ff, cmd_in;
   logic [trcw_pkg::WORD_W-1:0]  ack_ff, ack_in;
   logic [trcw_pkg::WORD_W-1:0]  nxt_ff, nxt_in;
   logic [trcw_pkg::MSS_W-1:0]   pwin_ff, pwin_in;

   logic [trcw_pkg::WORD_W-1:0]  unacked_ff, unacked_in;
   logic [trcw_pkg::WORD_W-1:0]  win_ff, win_in;
   logic [trcw_pkg::WORD_W-1:0]  thr_ff, thr_in;
   logic [trcw_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [trcw_pkg::DUP_W-1:0]   dup_ff, dup_in;
   logic [trcw_pkg::WORD_W-1:0]  mark_ff, mark_in;
   logic [trcw_pkg::MSS_W-1:0]   adv_ff, adv_in;
   logic                         resend_ff, resend_in;
   logic                         reopen_ff, reopen_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [trcw_pkg::WORD_W-1:0]  rsp_win_ff, rsp_win_in;
   logic [trcw_pkg::WORD_W-1:0]  rsp_thr_ff, rsp_thr_in;
   logic [trcw_pkg::PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic                         rsp_resend_ff, rsp_resend_in;
   logic                         rsp_reopen_ff, rsp_reopen_in;

   logic                         new_ack;
   logic                         dup_ack;
   logic                         partial;
   logic [trcw_pkg::DUP_W-1:0]   dup_next;
   logic                         third_dup;
   logic [trcw_pkg::MSS_W+1:0]   mss_x3;
   logic [trcw_pkg::WORD_W-1:0]  add_a;
   logic [trcw_pkg::WORD_W-1:0]  add_b;
   logic [trcw_pkg::WORD_W:0]    add_sum;
   logic [trcw_pkg::WORD_W-1:0]  add_sat;
   logic [trcw_pkg::WORD_W-1:0]  mss_sq;
   logic                         div_start;
   logic                         div_done;
   logic [trcw_pkg::WORD_W-1:0]  div_quo;
   logic                         csr_write;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == trcw_pkg::CSR_IDX_SEGMENT_SIZE)
                      ? {{(trcw_pkg::CSR_DATA_W - trcw_pkg::MSS_W){1'b0}}, mss_ff}
                      : '0;

   always_comb begin
      mss_in = mss_ff;
      if (csr_write && paddr[2] == trcw_pkg::CSR_IDX_SEGMENT_SIZE) begin
         mss_in = pwdata[trcw_pkg::MSS_W-1:0];
      end
   end

   // classify the held transaction
   assign new_ack   = ack_ff > unacked_ff;
   assign dup_ack   = ack_ff == unacked_ff;
   assign partial   = (phase_ff == trcw_pkg::PHASE_RECOVERY) && (ack_ff < mark_ff);
   assign dup_next  = (dup_ff < trcw_pkg::DUP_MAX) ? dup_ff + 1'b1 : dup_ff;
   assign third_dup = dup_ack && (dup_next == trcw_pkg::FAST_DUPS);
   assign mss_x3    = {1'b0, mss_ff, 1'b0} + {2'b00, mss_ff};
   assign mss_sq    = trcw_pkg::WORD_W'(mss_ff) * trcw_pkg::WORD_W'(mss_ff);

   // shared saturating adder
   always_comb begin
      add_a = win_ff;
      add_b = trcw_pkg::WORD_W'(mss_ff);
      if (state_ff == trcw_pkg::ST_GROW) begin
         add_b = div_quo;
      end else if (third_dup) begin
         add_a = {1'b0, win_ff[trcw_pkg::WORD_W-1:1]};
         add_b = trcw_pkg::WORD_W'(mss_x3);
      end
   end

   assign add_sum = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat = add_sum[trcw_pkg::WORD_W] ? '1 : add_sum[trcw_pkg::WORD_W-1:0];

   trcw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mss_sq),
      .divisor  (win_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ack_in        = ack_ff;
      nxt_in        = nxt_ff;
      pwin_in       = pwin_ff;
      unacked_in    = unacked_ff;
      win_in        = win_ff;
      thr_in        = thr_ff;
      phase_in      = phase_ff;
      dup_in        = dup_ff;
      mark_in       = mark_ff;
      adv_in        = adv_ff;
      resend_in     = resend_ff;
      reopen_in     = reopen_ff;
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_win_in    = rsp_win_ff;
      rsp_thr_in    = rsp_thr_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_resend_in = rsp_resend_ff;
      rsp_reopen_in = rsp_reopen_ff;
      unique case (state_ff)
         trcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               ack_in   = req_ack_num;
               nxt_in   = req_snd_next;
               pwin_in  = req_peer_window;
               state_in = trcw_pkg::ST_EVAL;
            end
         end
         trcw_pkg::ST_EVAL: begin
            resend_in = 1'b0;
            reopen_in = 1'b0;
            state_in  = trcw_pkg::ST_PUSH;
            if (cmd_ff == trcw_pkg::CMD_ESTABLISH) begin
               unacked_in = ack_ff;
               win_in     = trcw_pkg::WORD_W'(mss_ff);
               thr_in     = trcw_pkg::WORD_W'(pwin_ff);
               adv_in     = pwin_ff;
               phase_in   = trcw_pkg::PHASE_OPEN;
               dup_in     = '0;
            end else begin
               if (new_ack) begin
                  unacked_in = ack_ff;
                  if (partial) begin
                     resend_in = 1'b1;
                  end else begin
                     phase_in = trcw_pkg::PHASE_OPEN;
                     if (phase_ff != trcw_pkg::PHASE_OPEN) begin
                        dup_in = '0;
                     end
                     if (win_ff < thr_ff) begin
                        win_in = add_sat;
                     end else begin
                        div_start = 1'b1;
                        state_in  = trcw_pkg::ST_DIVIDE;
                     end
                  end
               end else if (dup_ack) begin
                  dup_in = dup_next;
                  if (dup_next == trcw_pkg::DUP_ONE) begin
                     phase_in = trcw_pkg::PHASE_DISORDER;
                  end else if (third_dup) begin
                     phase_in  = trcw_pkg::PHASE_RECOVERY;
                     mark_in   = nxt_ff;
                     resend_in = 1'b1;
                     thr_in    = {1'b0, win_ff[trcw_pkg::WORD_W-1:1]};
                     win_in    = add_sat;
                  end else if (dup_next > trcw_pkg::FAST_DUPS) begin
                     win_in    = add_sat;
                     resend_in = 1'b1;
                  end
               end
               reopen_in = (adv_ff == '0) && (pwin_ff != '0);
               adv_in    = pwin_ff;
            end
         end
         trcw_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = trcw_pkg::ST_GROW;
            end
         end
         trcw_pkg::ST_GROW: begin
            win_in   = add_sat;
            state_in = trcw_pkg::ST_PUSH;
         end
         trcw_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_win_in    = win_ff;
               rsp_thr_in    = thr_ff;
               rsp_phase_in  = phase_ff;
               rsp_resend_in = resend_ff;
               rsp_reopen_in = reopen_ff;
               state_in      = trcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trcw_pkg::ST_IDLE;
         mss_ff       <= trcw_pkg::MSS_RESET;
         unacked_ff   <= '0;
         win_ff       <= '0;
         thr_ff       <= '0;
         phase_ff     <= trcw_pkg::PHASE_OPEN;
         dup_ff       <= '0;
         mark_ff      <= '0;
         adv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mss_ff       <= mss_in;
         unacked_ff   <= unacked_in;
         win_ff       <= win_in;
         thr_ff       <= thr_in;
         phase_ff     <= phase_in;
         dup_ff       <= dup_in;
         mark_ff      <= mark_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      ack_ff        <= ack_in;
      nxt_ff        <= nxt_in;
      pwin_ff       <= pwin_in;
      resend_ff     <= resend_in;
      reopen_ff     <= reopen_in;
      rsp_win_ff    <= rsp_win_in;
      rsp_thr_ff    <= rsp_thr_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_resend_ff <= rsp_resend_in;
      rsp_reopen_ff <= rsp_reopen_in;
   end

   assign req_ready            = state_ff == trcw_pkg::ST_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cong_window      = rsp_win_ff;
   assign rsp_slow_start_limit = rsp_thr_ff;
   assign rsp_cong_phase       = rsp_phase_ff;
   assign rsp_retransmit       = rsp_resend_ff;
   assign rsp_window_reopened  = rsp_reopen_ff;

`ifndef SYNTH
   a_accept_to_eval : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == trcw_pkg::ST_EVAL))
      else $error("accepted transaction did not enter evaluation");

   a_div_done_in_divide : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == trcw_pkg::ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_phase_code : assert property (@(posedge clock) disable iff (reset)
      phase_ff != trcw_pkg::PHASE_UNUSED)
      else $error("congestion phase took the unused code");

   a_push_loads_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == trcw_pkg::ST_PUSH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not loaded into the free output register");
`endif

endmodule
